FILE: hdl/ppu_pkg.sv
// ppu_pkg: shared types, codes, widths and helper functions of the particle update
// used by ppu_lane and particle_physics_update; depends on nothing

package ppu_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int FT_W    = 16;
    localparam int RAMP_W  = 16;
    localparam int TIME_W  = 48;
    localparam int KIND_W  = 3;
    localparam int COL_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    // internal arithmetic widths
    localparam int PROD_W = 49;   // vel * ft, signed
    localparam int T1_W   = 34;   // round(vel*ft / 2^16)
    localparam int T4_W   = 36;   // round(4*vel*ft / 2^16)
    localparam int SUM_W  = 38;   // unsaturated velocity / position sum
    localparam int ADJ_W  = 20;   // gravity or heavy term, signed
    localparam int GRAV_W = 14;
    localparam int HEAVY_W = 19;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOW_TIME   = 2'd2;

    // particle kinds
    localparam logic [KIND_W-1:0] KIND_STATIC   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GRAV     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SLOWGRAV = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPLODE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EXPLODE2 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BLOB     = 3'd6;
    localparam logic [KIND_W-1:0] KIND_BLOB2    = 3'd7;

    // per-lane velocity operation
    typedef logic [1:0] vop_t;
    localparam vop_t VOP_NONE = 2'd0;
    localparam vop_t VOP_ADD4 = 2'd1;
    localparam vop_t VOP_SUB1 = 2'd2;
    localparam vop_t VOP_SUB4 = 2'd3;

    // death time of a killed particle
    localparam logic [TIME_W-1:0] DEATH_DEAD = 48'hFFFF_FFFF_FFFF;

    // ramp limits, Q4.12
    localparam logic [RAMP_W-1:0] RAMP_LIM_FIRE    = 16'd24576;
    localparam logic [RAMP_W-1:0] RAMP_LIM_EXPLODE = 16'd32768;

    // saturate a wide signed sum to 32 bits
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [POS_W-1:0] r;
        if (x > 38'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -38'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[POS_W-1:0];
        return r;
    endfunction

    // colour ramp tables for fire and the two explosion kinds
    function automatic logic [COL_W-1:0] ramp_colour(input logic [KIND_W-1:0] kind,
                                                     input logic [2:0] idx);
        logic [COL_W-1:0] c;
        c = 8'h00;
        if (kind == KIND_FIRE) begin
            case (idx)
                3'd0:    c = 8'h6d;
                3'd1:    c = 8'h6b;
                3'd2:    c = 8'h06;
                3'd3:    c = 8'h05;
                3'd4:    c = 8'h04;
                3'd5:    c = 8'h03;
                default: c = 8'h00;
            endcase
        end else if (kind == KIND_EXPLODE) begin
            case (idx)
                3'd0:    c = 8'h6f;
                3'd1:    c = 8'h6d;
                3'd2:    c = 8'h6b;
                3'd3:    c = 8'h69;
                3'd4:    c = 8'h67;
                3'd5:    c = 8'h65;
                3'd6:    c = 8'h63;
                default: c = 8'h61;
            endcase
        end else begin
            case (idx)
                3'd0:    c = 8'h6f;
                3'd1:    c = 8'h6e;
                3'd2:    c = 8'h6d;
                3'd3:    c = 8'h6c;
                3'd4:    c = 8'h6b;
                3'd5:    c = 8'h6a;
                3'd6:    c = 8'h68;
                default: c = 8'h66;
            endcase
        end
        return c;
    endfunction

endpackage

FILE: hdl/ppu_lane.sv
// ppu_lane: one axis of the particle update, position advance and velocity rule
// three register stages (multiply, round, add); uses ppu_pkg

module ppu_lane (
    input  logic                               clk,
    input  logic signed [ppu_pkg::POS_W-1:0]   pos,
    input  logic signed [ppu_pkg::POS_W-1:0]   vel,
    input  logic        [ppu_pkg::FT_W-1:0]    ft,
    input  ppu_pkg::vop_t                      vop,
    input  logic signed [ppu_pkg::ADJ_W-1:0]   adj,
    output logic signed [ppu_pkg::POS_W-1:0]   pos_orig,
    output logic signed [ppu_pkg::POS_W-1:0]   vel_orig,
    output logic signed [ppu_pkg::POS_W-1:0]   npos,
    output logic signed [ppu_pkg::POS_W-1:0]   nvel
);
    import ppu_pkg::*;

    // stage b: product
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic signed [POS_W-1:0]  pos_b_reg;
    logic signed [POS_W-1:0]  vel_b_reg;
    vop_t                     vop_b_reg;

    // stage c: rounded terms
    logic signed [PROD_W:0]   r1;
    logic signed [PROD_W+2:0] r4;
    logic signed [T1_W-1:0]   t1_next;
    logic signed [T4_W-1:0]   t4_next;
    logic signed [T1_W-1:0]   t1_c_reg;
    logic signed [T4_W-1:0]   t4_c_reg;
    logic signed [POS_W-1:0]  pos_c_reg;
    logic signed [POS_W-1:0]  vel_c_reg;
    vop_t                     vop_c_reg;

    // stage d: sums
    logic signed [T1_W-1:0]   psum;
    logic signed [SUM_W-1:0]  term;
    logic signed [POS_W-1:0]  npos_next;
    logic signed [SUM_W-1:0]  vsum_next;
    logic signed [POS_W-1:0]  npos_d_reg;
    logic signed [SUM_W-1:0]  vsum_d_reg;
    logic signed [POS_W-1:0]  pos_d_reg;
    logic signed [POS_W-1:0]  vel_d_reg;

    // velocity times frame time
    assign prod_next = vel * $signed({1'b0, ft});

    always_ff @(posedge clk)
    begin
        prod_b_reg <= prod_next;
        pos_b_reg  <= pos;
        vel_b_reg  <= vel;
        vop_b_reg  <= vop;
    end

    // round to nearest, ties up, for x/2^16 and 4x/2^16
    assign r1 = {prod_b_reg[PROD_W-1], prod_b_reg} + (PROD_W+1)'(32768);
    assign r4 = {prod_b_reg[PROD_W-1], prod_b_reg, 2'b00} + (PROD_W+3)'(32768);
    assign t1_next = r1[PROD_W:16];
    assign t4_next = r4[PROD_W+2:16];

    always_ff @(posedge clk)
    begin
        t1_c_reg  <= t1_next;
        t4_c_reg  <= t4_next;
        pos_c_reg <= pos_b_reg;
        vel_c_reg <= vel_b_reg;
        vop_c_reg <= vop_b_reg;
    end

    // velocity term by kind rule
    always_comb
    begin
        term = '0;
        unique case (vop_c_reg)
            VOP_NONE: term = '0;
            VOP_ADD4: term = {{(SUM_W-T4_W){t4_c_reg[T4_W-1]}}, t4_c_reg};
            VOP_SUB1: term = -{{(SUM_W-T1_W){t1_c_reg[T1_W-1]}}, t1_c_reg};
            VOP_SUB4: term = -{{(SUM_W-T4_W){t4_c_reg[T4_W-1]}}, t4_c_reg};
            default:  term = '0;
        endcase
    end

    // position advance and exact velocity sum
    assign psum = {{(T1_W-POS_W){pos_c_reg[POS_W-1]}}, pos_c_reg} + t1_c_reg;
    assign npos_next = sat32({{(SUM_W-T1_W){psum[T1_W-1]}}, psum});
    assign vsum_next = {{(SUM_W-POS_W){vel_c_reg[POS_W-1]}}, vel_c_reg} + term
                     + {{(SUM_W-ADJ_W){adj[ADJ_W-1]}}, adj};

    always_ff @(posedge clk)
    begin
        npos_d_reg <= npos_next;
        vsum_d_reg <= vsum_next;
        pos_d_reg  <= pos_c_reg;
        vel_d_reg  <= vel_c_reg;
    end

    assign pos_orig = pos_d_reg;
    assign vel_orig = vel_d_reg;
    assign npos     = npos_d_reg;
    assign nvel     = sat32(vsum_d_reg);

endmodule

FILE: hdl/particle_physics_update.sv
// particle_physics_update: per-frame update of one particle per transaction
// instantiates three ppu_lane axes; uses ppu_pkg
//
// Usage:
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 frame_time, 1 paused, 2 now_time) at the clock edge; index 3 is ignored.
//   Write registers only while no transaction is in flight.
//   Input: a transaction is taken at each rising edge with start high and
//   busy low. busy is held low: the pipeline takes one particle every cycle.
//   Output: done is high for exactly one cycle with the result on the
//   new_* ports, removed and colour_out; the receiver takes it in that cycle.
// Pipeline and throughput:
//   five stages (input, multiply, round, add, output register); the result
//   of a transaction passes the input, multiply, round, add and output
//   registers in that order. One particle per cycle sustained, set by the single
//   32x17 multiplier per axis that is pipelined behind its own register.
// Reset:
//   rst_n clears the configuration registers and all valid bits; no result
//   is lost or repeated since the receiver cannot stall.

module particle_physics_update (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [ppu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppu_pkg::CFG_DAT_W-1:0]        cfg_data,
    // command
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ppu_pkg::POS_W-1:0]     pos_x,
    input  logic signed [ppu_pkg::POS_W-1:0]     pos_y,
    input  logic signed [ppu_pkg::POS_W-1:0]     pos_z,
    input  logic signed [ppu_pkg::POS_W-1:0]     vel_x,
    input  logic signed [ppu_pkg::POS_W-1:0]     vel_y,
    input  logic signed [ppu_pkg::POS_W-1:0]     vel_z,
    input  logic        [ppu_pkg::RAMP_W-1:0]    ramp_pos,
    input  logic signed [ppu_pkg::TIME_W-1:0]    death_time,
    input  logic        [ppu_pkg::KIND_W-1:0]    kind,
    input  logic        [ppu_pkg::COL_W-1:0]     colour_in,
    // result
    output logic                                 done,
    output logic                                 removed,
    output logic signed [ppu_pkg::POS_W-1:0]     new_pos_x,
    output logic signed [ppu_pkg::POS_W-1:0]     new_pos_y,
    output logic signed [ppu_pkg::POS_W-1:0]     new_pos_z,
    output logic signed [ppu_pkg::POS_W-1:0]     new_vel_x,
    output logic signed [ppu_pkg::POS_W-1:0]     new_vel_y,
    output logic signed [ppu_pkg::POS_W-1:0]     new_vel_z,
    output logic        [ppu_pkg::RAMP_W-1:0]    new_ramp_pos,
    output logic signed [ppu_pkg::TIME_W-1:0]    new_death_time,
    output logic        [ppu_pkg::COL_W-1:0]     colour_out
);
    import ppu_pkg::*;

    // configuration registers
    logic [FT_W-1:0]          frame_time_reg;
    logic                     paused_reg;
    logic signed [TIME_W-1:0] now_time_reg;
    logic [FT_W-1:0]          ft;

    // stage a: captured transaction
    logic                     a_valid_reg;
    logic signed [POS_W-1:0]  a_pos_reg [3];
    logic signed [POS_W-1:0]  a_vel_reg [3];
    logic [RAMP_W-1:0]        a_ramp_reg;
    logic signed [TIME_W-1:0] a_death_reg;
    logic [KIND_W-1:0]        a_kind_reg;
    logic [COL_W-1:0]         a_colour_reg;
    vop_t                     vop_xy;
    vop_t                     vop_z;

    // stage b: constant products, expiry
    logic [21:0]              grav_prod;
    logic [26:0]              heavy_prod;
    logic [19:0]              step_prod;
    logic [3:0]               step_k;
    logic                     b_valid_reg;
    logic                     b_expired_reg;
    logic [RAMP_W-1:0]        b_ramp_reg;
    logic signed [TIME_W-1:0] b_death_reg;
    logic [KIND_W-1:0]        b_kind_reg;
    logic [COL_W-1:0]         b_colour_reg;
    logic [GRAV_W-1:0]        b_grav_reg;
    logic [HEAVY_W-1:0]       b_heavy_reg;
    logic [RAMP_W-1:0]        b_step_reg;

    // stage c: ramp sum, z adjust
    logic [RAMP_W:0]          ramp_sum;
    logic signed [ADJ_W-1:0]  adj_next;
    logic                     c_valid_reg;
    logic                     c_expired_reg;
    logic [RAMP_W-1:0]        c_ramp_reg;
    logic [RAMP_W-1:0]        c_ramp_new_reg;
    logic signed [TIME_W-1:0] c_death_reg;
    logic [KIND_W-1:0]        c_kind_reg;
    logic [COL_W-1:0]         c_colour_reg;
    logic signed [ADJ_W-1:0]  c_adj_reg;

    // stage d: ramp outcome
    logic [RAMP_W-1:0]        ramp_lim;
    logic signed [TIME_W-1:0] death_next;
    logic [COL_W-1:0]         colour_next;
    logic                     d_valid_reg;
    logic                     d_expired_reg;
    logic [RAMP_W-1:0]        d_ramp_reg;
    logic [RAMP_W-1:0]        d_ramp_new_reg;
    logic signed [TIME_W-1:0] d_death_reg;
    logic signed [TIME_W-1:0] d_death_new_reg;
    logic [COL_W-1:0]         d_colour_reg;
    logic [COL_W-1:0]         d_colour_new_reg;

    // lane results at stage d
    logic signed [POS_W-1:0]  l_pos [3];
    logic signed [POS_W-1:0]  l_vel [3];
    logic signed [POS_W-1:0]  l_npos [3];
    logic signed [POS_W-1:0]  l_nvel [3];

    // output registers
    logic                     done_reg;
    logic                     removed_reg;
    logic signed [POS_W-1:0]  out_pos_reg [3];
    logic signed [POS_W-1:0]  out_vel_reg [3];
    logic [RAMP_W-1:0]        out_ramp_reg;
    logic signed [TIME_W-1:0] out_death_reg;
    logic [COL_W-1:0]         out_colour_reg;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_time_reg <= '0;
            paused_reg     <= 1'b0;
            now_time_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_TIME: frame_time_reg <= cfg_data[FT_W-1:0];
                REG_PAUSED:     paused_reg     <= cfg_data[0];
                REG_NOW_TIME:   now_time_reg   <= cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    assign ft   = paused_reg ? '0 : frame_time_reg;
    assign busy = 1'b0;

    // stage a capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        a_pos_reg[0] <= pos_x;
        a_pos_reg[1] <= pos_y;
        a_pos_reg[2] <= pos_z;
        a_vel_reg[0] <= vel_x;
        a_vel_reg[1] <= vel_y;
        a_vel_reg[2] <= vel_z;
        a_ramp_reg   <= ramp_pos;
        a_death_reg  <= death_time;
        a_kind_reg   <= kind;
        a_colour_reg <= colour_in;
    end

    // velocity operation per kind
    always_comb
    begin
        vop_xy = VOP_NONE;
        vop_z  = VOP_NONE;
        case (a_kind_reg) inside
            KIND_EXPLODE, KIND_BLOB: begin
                vop_xy = VOP_ADD4;
                vop_z  = VOP_ADD4;
            end
            KIND_EXPLODE2: begin
                vop_xy = VOP_SUB1;
                vop_z  = VOP_SUB1;
            end
            KIND_BLOB2: begin
                vop_xy = VOP_SUB4;
                vop_z  = VOP_NONE;
            end
            default: begin
                vop_xy = VOP_NONE;
                vop_z  = VOP_NONE;
            end
        endcase
    end

    // constant multiplies and ramp step
    always_comb
    begin
        case (a_kind_reg)
            KIND_FIRE:     step_k = 4'd5;
            KIND_EXPLODE:  step_k = 4'd10;
            KIND_EXPLODE2: step_k = 4'd15;
            default:       step_k = 4'd0;
        endcase
    end

    assign grav_prod  = 22'(ft) * 22'd40 + 22'd128;
    assign heavy_prod = 27'(ft) * 27'd1200 + 27'd128;
    assign step_prod  = 20'(ft) * 20'(step_k) + 20'd8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_expired_reg <= a_death_reg < now_time_reg;
        b_ramp_reg    <= a_ramp_reg;
        b_death_reg   <= a_death_reg;
        b_kind_reg    <= a_kind_reg;
        b_colour_reg  <= a_colour_reg;
        b_grav_reg    <= grav_prod[21:8];
        b_heavy_reg   <= heavy_prod[26:8];
        b_step_reg    <= step_prod[19:4];
    end

    // ramp advance with saturation, z adjust by kind
    assign ramp_sum = {1'b0, b_ramp_reg} + {1'b0, b_step_reg};

    always_comb
    begin
        case (b_kind_reg) inside
            KIND_GRAV, KIND_SLOWGRAV, KIND_BLOB, KIND_BLOB2:
                adj_next = -$signed({{(ADJ_W-GRAV_W){1'b0}}, b_grav_reg});
            KIND_FIRE:
                adj_next = $signed({{(ADJ_W-GRAV_W){1'b0}}, b_grav_reg});
            KIND_EXPLODE, KIND_EXPLODE2:
                adj_next = -$signed({{(ADJ_W-HEAVY_W){1'b0}}, b_heavy_reg});
            default:
                adj_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c_expired_reg  <= b_expired_reg;
        c_ramp_reg     <= b_ramp_reg;
        c_ramp_new_reg <= ramp_sum[RAMP_W] ? {RAMP_W{1'b1}} : ramp_sum[RAMP_W-1:0];
        c_death_reg    <= b_death_reg;
        c_kind_reg     <= b_kind_reg;
        c_colour_reg   <= b_colour_reg;
        c_adj_reg      <= adj_next;
    end

    // ramp end check and colour lookup
    assign ramp_lim = (c_kind_reg == KIND_FIRE) ? RAMP_LIM_FIRE : RAMP_LIM_EXPLODE;

    always_comb
    begin
        death_next  = c_death_reg;
        colour_next = c_colour_reg;
        case (c_kind_reg) inside
            KIND_FIRE, KIND_EXPLODE, KIND_EXPLODE2: begin
                if (c_ramp_new_reg >= ramp_lim)
                    death_next = DEATH_DEAD;
                else
                    colour_next = ramp_colour(c_kind_reg, c_ramp_new_reg[14:12]);
            end
            default: begin
                death_next  = c_death_reg;
                colour_next = c_colour_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        d_expired_reg    <= c_expired_reg;
        d_ramp_reg       <= c_ramp_reg;
        d_ramp_new_reg   <= c_ramp_new_reg;
        d_death_reg      <= c_death_reg;
        d_death_new_reg  <= death_next;
        d_colour_reg     <= c_colour_reg;
        d_colour_new_reg <= colour_next;
    end

    // axis lanes
    ppu_lane u_lane_x (
        .clk      (clk),
        .pos      (a_pos_reg[0]),
        .vel      (a_vel_reg[0]),
        .ft       (ft),
        .vop      (vop_xy),
        .adj      ('0),
        .pos_orig (l_pos[0]),
        .vel_orig (l_vel[0]),
        .npos     (l_npos[0]),
        .nvel     (l_nvel[0])
    );

    ppu_lane u_lane_y (
        .clk      (clk),
        .pos      (a_pos_reg[1]),
        .vel      (a_vel_reg[1]),
        .ft       (ft),
        .vop      (vop_xy),
        .adj      ('0),
        .pos_orig (l_pos[1]),
        .vel_orig (l_vel[1]),
        .npos     (l_npos[1]),
        .nvel     (l_nvel[1])
    );

    ppu_lane u_lane_z (
        .clk      (clk),
        .pos      (a_pos_reg[2]),
        .vel      (a_vel_reg[2]),
        .ft       (ft),
        .vop      (vop_z),
        .adj      (c_adj_reg),
        .pos_orig (l_pos[2]),
        .vel_orig (l_vel[2]),
        .npos     (l_npos[2]),
        .nvel     (l_nvel[2])
    );

    // output register, expired particles pass unchanged
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= d_expired_reg;
        for (int i = 0; i < 3; i++) begin
            out_pos_reg[i] <= d_expired_reg ? l_pos[i] : l_npos[i];
            out_vel_reg[i] <= d_expired_reg ? l_vel[i] : l_nvel[i];
        end
        out_ramp_reg   <= d_expired_reg ? d_ramp_reg : d_ramp_new_reg;
        out_death_reg  <= d_expired_reg ? d_death_reg : d_death_new_reg;
        out_colour_reg <= d_expired_reg ? d_colour_reg : d_colour_new_reg;
    end

    assign done           = done_reg;
    assign removed        = removed_reg;
    assign new_pos_x      = out_pos_reg[0];
    assign new_pos_y      = out_pos_reg[1];
    assign new_pos_z      = out_pos_reg[2];
    assign new_vel_x      = out_vel_reg[0];
    assign new_vel_y      = out_vel_reg[1];
    assign new_vel_z      = out_vel_reg[2];
    assign new_ramp_pos   = out_ramp_reg;
    assign new_death_time = out_death_reg;
    assign colour_out     = out_colour_reg;

    // each accepted transaction is followed by its result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("result strobe missing after accepted transaction");

    // no result strobe without a transaction in the last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !d_valid_reg |=> !done)
        else $error("result strobe without a transaction");

    // a removed particle died before the current time
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && removed) |-> (new_death_time < now_time_reg))
        else $error("removed particle with death time not before now");

    // the pipeline never refuses a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

FILE: tb/particle_physics_update_tb.sv
`timescale 1ns / 100ps
// particle_physics_update_tb: self-checking bench for the per-frame particle update
// drives directed and random particles under several register settings, predicts each
// update in the bench itself; depends on ppu_pkg and particle_physics_update

module particle_physics_update_tb;

    import ppu_pkg::*;

    localparam int     LATENCY   = 5;
    localparam int     LIMIT     = 200000;
    localparam longint WORD_MAX  = 64'sd2147483647;
    localparam longint WORD_MIN  = -64'sd2147483648;
    localparam longint TIME_MAX_L = (longint'(1) << 47) - 1;
    localparam longint TIME_MIN_L = -(longint'(1) << 47);
    localparam logic signed [TIME_W-1:0] TIME_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [TIME_W-1:0] TIME_MIN = 48'sh8000_0000_0000;
    localparam logic [CFG_IDX_W-1:0]     REG_UNUSED = 2'd3;

    // palette ramps, indexed by the integer part of the ramp position
    localparam logic [0:7][COL_W-1:0] FIRE_COLOURS =
        {8'h6d, 8'h6b, 8'h06, 8'h05, 8'h04, 8'h03, 8'h00, 8'h00};
    localparam logic [0:7][COL_W-1:0] BURST_COLOURS =
        {8'h6f, 8'h6d, 8'h6b, 8'h69, 8'h67, 8'h65, 8'h63, 8'h61};
    localparam logic [0:7][COL_W-1:0] FADE_COLOURS =
        {8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6b, 8'h6a, 8'h68, 8'h66};

    typedef struct packed {
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic signed [POS_W-1:0]  vx;
        logic signed [POS_W-1:0]  vy;
        logic signed [POS_W-1:0]  vz;
        logic [RAMP_W-1:0]        ramp;
        logic signed [TIME_W-1:0] death;
        logic [KIND_W-1:0]        kind;
        logic [COL_W-1:0]         colour;
    } spark_rec_t;

    typedef struct packed {
        logic       removed;
        spark_rec_t p;
    } update_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic start;
    logic busy;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic [RAMP_W-1:0] ramp_pos;
    logic signed [TIME_W-1:0] death_time;
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0] colour_in;
    logic done;
    logic removed;
    logic signed [POS_W-1:0] new_pos_x, new_pos_y, new_pos_z;
    logic signed [POS_W-1:0] new_vel_x, new_vel_y, new_vel_z;
    logic [RAMP_W-1:0] new_ramp_pos;
    logic signed [TIME_W-1:0] new_death_time;
    logic [COL_W-1:0] colour_out;

    // bench copy of the registers
    logic [FT_W-1:0]          cfg_frame_time;
    logic                     cfg_paused;
    logic signed [TIME_W-1:0] cfg_now;

    update_t pending_updates[$];
    int      n_items;
    int      n_checked;
    int      n_expired;
    int      n_burned_out;
    int      n_settings;
    int      n_errors;
    bit      no_idle;

    particle_physics_update dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .ramp_pos(ramp_pos), .death_time(death_time), .kind(kind), .colour_in(colour_in),
        .done(done), .removed(removed),
        .new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z),
        .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
        .new_ramp_pos(new_ramp_pos), .new_death_time(new_death_time),
        .colour_out(colour_out)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // round to nearest, ties up, then drop n fraction bits
    function automatic longint round_shift(input longint x, input int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(input longint x);
        if (x > WORD_MAX)
            return WORD_MAX;
        if (x < WORD_MIN)
            return WORD_MIN;
        return x;
    endfunction

    // expected update of one particle under the current registers
    function automatic update_t update_particle(input spark_rec_t p);
        update_t    r;
        longint     pin[3];
        longint     vin[3];
        longint     npos[3];
        longint     nvel[3];
        longint     ft, grav, heavy, ramp, death, lim, gain;
        logic [2:0] idx;
        pin[0] = $signed(p.px);
        pin[1] = $signed(p.py);
        pin[2] = $signed(p.pz);
        vin[0] = $signed(p.vx);
        vin[1] = $signed(p.vy);
        vin[2] = $signed(p.vz);
        ramp   = p.ramp;
        death  = $signed(p.death);
        r.removed = 1'b1;
        r.p = p;
        // expired particles pass through untouched
        if (death < longint'(cfg_now))
            return r;
        r.removed = 1'b0;
        ft    = cfg_paused ? 0 : longint'(cfg_frame_time);
        grav  = round_shift(ft * 40, 8);
        heavy = round_shift(ft * 1200, 8);
        for (int i = 0; i < 3; i++)
        begin
            npos[i] = clip32(pin[i] + round_shift(vin[i] * ft, 16));
            nvel[i] = vin[i];
        end
        case (p.kind) inside
            KIND_FIRE, KIND_EXPLODE, KIND_EXPLODE2:
            begin
                gain = (p.kind == KIND_FIRE) ? 5 : (p.kind == KIND_EXPLODE) ? 10 : 15;
                lim  = (p.kind == KIND_FIRE) ? RAMP_LIM_FIRE : RAMP_LIM_EXPLODE;
                ramp = ramp + round_shift(ft * gain, 4);
                if (ramp > 65535)
                    ramp = 65535;
                // ramp past the end of its table kills the particle
                if (ramp >= lim)
                    death = -1;
                else
                begin
                    idx = ramp[14:12];
                    r.p.colour = (p.kind == KIND_FIRE)    ? FIRE_COLOURS[idx] :
                                 (p.kind == KIND_EXPLODE) ? BURST_COLOURS[idx] :
                                                            FADE_COLOURS[idx];
                end
                if (p.kind == KIND_FIRE)
                    nvel[2] = nvel[2] + grav;
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (p.kind == KIND_EXPLODE)
                            nvel[i] = nvel[i] + round_shift(vin[i] * ft * 4, 16);
                        else
                            nvel[i] = nvel[i] - round_shift(vin[i] * ft, 16);
                    end
                    nvel[2] = nvel[2] - heavy;
                end
            end
            KIND_BLOB:
            begin
                for (int i = 0; i < 3; i++)
                    nvel[i] = nvel[i] + round_shift(vin[i] * ft * 4, 16);
                nvel[2] = nvel[2] - grav;
            end
            KIND_BLOB2:
            begin
                for (int i = 0; i < 2; i++)
                    nvel[i] = nvel[i] - round_shift(vin[i] * ft * 4, 16);
                nvel[2] = nvel[2] - grav;
            end
            KIND_GRAV, KIND_SLOWGRAV:
                nvel[2] = nvel[2] - grav;
            default: ;
        endcase
        for (int i = 0; i < 3; i++)
            nvel[i] = clip32(nvel[i]);
        r.p.px    = npos[0][31:0];
        r.p.py    = npos[1][31:0];
        r.p.pz    = npos[2][31:0];
        r.p.vx    = nvel[0][31:0];
        r.p.vy    = nvel[1][31:0];
        r.p.vz    = nvel[2][31:0];
        r.p.ramp  = ramp[15:0];
        r.p.death = death[47:0];
        return r;
    endfunction

    // random value generators
    function automatic logic [31:0] rand_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'h7FFF_FFFF;
        if (sel == 1)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] small_speed();
        return $urandom_range(0, 2097152) - 32'd1048576;
    endfunction

    function automatic logic [31:0] rand_speed();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return small_speed();
        if (sel == 5)
            return 32'h7FFF_FFFF;
        if (sel == 6)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    // live particle with small speeds, fields overridden by the directed tests
    function automatic spark_rec_t live_particle(input logic [KIND_W-1:0] k);
        spark_rec_t p;
        p.px     = $urandom;
        p.py     = $urandom;
        p.pz     = $urandom;
        p.vx     = small_speed();
        p.vy     = small_speed();
        p.vz     = small_speed();
        p.ramp   = '0;
        p.death  = TIME_MAX;
        p.kind   = k;
        p.colour = COL_W'($urandom);
        return p;
    endfunction

    // mostly live particles near the current time, some expired, some anywhere
    function automatic spark_rec_t random_particle();
        spark_rec_t p;
        longint     d;
        int         sel;
        p.px     = rand_word();
        p.py     = rand_word();
        p.pz     = rand_word();
        p.vx     = rand_speed();
        p.vy     = rand_speed();
        p.vz     = rand_speed();
        p.ramp   = $urandom_range(0, 1) ? 16'($urandom_range(20000, 33000)) : 16'($urandom);
        p.kind   = KIND_W'($urandom_range(0, 7));
        p.colour = COL_W'($urandom);
        sel = $urandom_range(0, 9);
        d = cfg_now;
        if (sel < 6)
            d = d + longint'($urandom_range(0, 16777215));
        else if (sel < 8)
            d = d - longint'($urandom_range(1, 16777215));
        else if (sel == 8)
            d = $signed(48'({$urandom, $urandom}));
        if (d > TIME_MAX_L)
            d = TIME_MAX_L;
        if (d < TIME_MIN_L)
            d = TIME_MIN_L;
        p.death = d[47:0];
        return p;
    endfunction

    function automatic int pick_gap();
        int sel;
        if (no_idle)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one transaction on the command port, then an optional idle gap
    task automatic send_particle(input spark_rec_t p);
        update_t r;
        int      gap;
        pos_x      <= p.px;
        pos_y      <= p.py;
        pos_z      <= p.pz;
        vel_x      <= p.vx;
        vel_y      <= p.vy;
        vel_z      <= p.vz;
        ramp_pos   <= p.ramp;
        death_time <= p.death;
        kind       <= p.kind;
        colour_in  <= p.colour;
        start      <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = update_particle(p);
        pending_updates.push_back(r);
        n_items++;
        if (r.removed)
            n_expired++;
        else if (r.p.death == DEATH_DEAD)
            n_burned_out++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding update
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // register write, cfg_we left high for a following write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_FRAME_TIME: cfg_frame_time = data[FT_W-1:0];
            REG_PAUSED:     cfg_paused = data[0];
            REG_NOW_TIME:   cfg_now = data;
            default: ;
        endcase
    endtask

    // idle the block, then write all three registers; upper data bits carry junk
    task automatic set_config(input logic [FT_W-1:0] ft, input logic pause,
                              input logic [TIME_W-1:0] now);
        logic [CFG_DAT_W-1:0] junk;
        drain_pipeline();
        junk = CFG_DAT_W'({$urandom, $urandom});
        write_register(REG_FRAME_TIME, {junk[CFG_DAT_W-1:FT_W], ft});
        write_register(REG_PAUSED, {junk[CFG_DAT_W-1:1], pause});
        write_register(REG_NOW_TIME, now);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function void check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // compare each result transaction with the oldest expected update
    always @(posedge clk)
    begin
        update_t want;
        if (rst_n && done)
        begin
            if (pending_updates.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got pos_x %h",
                         $time, new_pos_x);
                n_errors++;
            end
            else
            begin
                want = pending_updates.pop_front();
                check_field("removed", 64'(want.removed), 64'(removed));
                check_field("new_pos_x", 64'(want.p.px), 64'(new_pos_x));
                check_field("new_pos_y", 64'(want.p.py), 64'(new_pos_y));
                check_field("new_pos_z", 64'(want.p.pz), 64'(new_pos_z));
                check_field("new_vel_x", 64'(want.p.vx), 64'(new_vel_x));
                check_field("new_vel_y", 64'(want.p.vy), 64'(new_vel_y));
                check_field("new_vel_z", 64'(want.p.vz), 64'(new_vel_z));
                check_field("new_ramp_pos", 64'(want.p.ramp), 64'(new_ramp_pos));
                check_field("new_death_time", 64'(want.p.death), 64'(new_death_time));
                check_field("colour_out", 64'(want.p.colour), 64'(colour_out));
                n_checked++;
            end
        end
    end

    // registers at their reset values: zero frame time, time zero
    task automatic test_power_on();
        spark_rec_t p;
        p = live_particle(KIND_GRAV);
        p.death = '0;
        send_particle(p);
        p = live_particle(KIND_FIRE);
        send_particle(p);
        p = live_particle(KIND_BLOB);
        p.death = DEATH_DEAD;
        send_particle(p);
    endtask

    // every kind once, then ramps running past their tables
    task automatic test_kind_rules();
        spark_rec_t p;
        set_config(16'h4000, 1'b0, '0);
        for (int k = 0; k < 8; k++)
        begin
            p = live_particle(k[KIND_W-1:0]);
            p.ramp = RAMP_W'($urandom_range(0, 20000));
            send_particle(p);
        end
        p = live_particle(KIND_FIRE);
        p.ramp = 16'd24000;
        send_particle(p);
        p = live_particle(KIND_EXPLODE);
        p.ramp = 16'd30000;
        send_particle(p);
        p = live_particle(KIND_EXPLODE2);
        p.ramp = 16'hFFFF;
        send_particle(p);
    endtask

    // full frame time with extreme positions and speeds
    task automatic test_saturation();
        spark_rec_t p;
        set_config(16'hFFFF, 1'b0, '0);
        p = live_particle(KIND_BLOB);
        {p.px, p.py, p.pz, p.vx, p.vy, p.vz} = {6{32'h7FFF_FFFF}};
        send_particle(p);
        p = live_particle(KIND_EXPLODE);
        {p.px, p.py, p.pz, p.vx, p.vy, p.vz} = {6{32'h8000_0000}};
        send_particle(p);
        p = live_particle(KIND_BLOB2);
        {p.px, p.py, p.pz} = {3{32'h7FFF_FFFF}};
        {p.vx, p.vy, p.vz} = {3{32'h8000_0000}};
        send_particle(p);
        p = live_particle(KIND_STATIC);
        p.ramp = 16'hFFFF;
        p.colour = 8'hFF;
        send_particle(p);
    endtask

    // death time against the current time, including both time extremes
    task automatic test_expiry();
        spark_rec_t p;
        logic signed [TIME_W-1:0] now;
        now = TIME_W'({$urandom, $urandom});
        now[TIME_W-1] = 1'b0;
        now[TIME_W-2] = 1'b0;
        set_config(16'($urandom), 1'b0, now);
        p = live_particle(KIND_GRAV);
        p.death = now - 1;
        send_particle(p);
        p = live_particle(KIND_FIRE);
        p.death = now;
        send_particle(p);
        p = live_particle(KIND_EXPLODE);
        p.death = TIME_MIN;
        send_particle(p);
        set_config(16'($urandom), 1'b0, TIME_MAX);
        p = live_particle(KIND_SLOWGRAV);
        send_particle(p);
        set_config(16'($urandom), 1'b0, TIME_MIN);
        p = live_particle(KIND_EXPLODE2);
        p.death = TIME_MIN;
        send_particle(p);
    endtask

    // pause freezes motion and ramps; a write to the spare index changes nothing
    task automatic test_pause();
        spark_rec_t p;
        set_config(16'hFFFF, 1'b1, '0);
        p = live_particle(KIND_FIRE);
        p.ramp = 16'd24575;
        send_particle(p);
        p = live_particle(KIND_EXPLODE2);
        send_particle(p);
        drain_pipeline();
        write_register(REG_UNUSED, CFG_DAT_W'({$urandom, $urandom}));
        cfg_we <= 1'b0;
        p = live_particle(KIND_BLOB);
        send_particle(p);
    endtask

    // random particles over a series of register settings
    task automatic test_random_traffic();
        logic [FT_W-1:0]   ft;
        logic [TIME_W-1:0] now;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:       ft = 16'hFFFF;
                1:       ft = FT_W'($urandom_range(1, 2000));
                2:       ft = FT_W'($urandom);
                default: ft = '0;
            endcase
            now = TIME_W'({$urandom, $urandom});
            if (ph == 2)
                now = TIME_MIN;
            else if (ph == 6)
                now = TIME_MAX;
            set_config(ft, ph == 5, now);
            no_idle = (ph == 3);
            for (int n = 0; n < 50; n++)
            begin
                if (ph == 4 && n == 25)
                    drain_pipeline();
                send_particle(random_particle());
            end
            no_idle = 1'b0;
        end
    endtask

    // run limit
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        start          = 1'b0;
        pos_x          = '0;
        pos_y          = '0;
        pos_z          = '0;
        vel_x          = '0;
        vel_y          = '0;
        vel_z          = '0;
        ramp_pos       = '0;
        death_time     = '0;
        kind           = KIND_STATIC;
        colour_in      = '0;
        cfg_frame_time = '0;
        cfg_paused     = 1'b0;
        cfg_now        = '0;
        no_idle        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_kind_rules();
        test_saturation();
        test_expiry();
        test_pause();
        test_random_traffic();
        drain_pipeline();

        $display("checked %0d of %0d particle updates over all 8 kinds and %0d settings",
                 n_checked, n_items, n_settings);
        $display("%0d expired on entry, %0d burned out at the end of their ramp",
                 n_expired, n_burned_out);
        if (n_errors == 0 && pending_updates.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
